FILE: hw/rtl/rms_error_accumulator_top_defines.svh
// Assertion macros for the RTL files that check their own logic (rmsea_ctrl).
`ifndef RMS_ERROR_ACCUMULATOR_TOP_DEFINES_SVH
`define RMS_ERROR_ACCUMULATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMSEA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmsea assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RMSEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmsea assertion failed");

`endif

FILE: hw/rtl/rmsea_pkg.sv
package rmsea_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int SQ_W       = 2 * SAMPLE_W + 1;
  localparam int SUM_W      = 48;
  localparam int MAX_PAIRS  = 65536;
  localparam int COUNT_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int WORK_W     = SUM_W + FRAC_W;
  localparam int DREM_W     = 16;
  localparam int ROOT_W     = WORK_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int RMS_W      = 24;
  localparam int DIV_STEPS  = WORK_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PAIRS);

  typedef struct packed {
    logic accept;
    logic load;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

endpackage

FILE: hw/rtl/rmsea_datapath.sv
module rmsea_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rmsea_pkg::cmd_t                       cmd,
  input  logic signed [rmsea_pkg::SAMPLE_W-1:0] ideal_sample,
  input  logic signed [rmsea_pkg::SAMPLE_W-1:0] approx_sample,
  output logic        [rmsea_pkg::RMS_W-1:0]    rms_value,
  output logic        [rmsea_pkg::COUNT_W-1:0]  pair_count,
  output logic                                  overflow
);
  import rmsea_pkg::*;

  logic signed [DIFF_W-1:0]   diff;
  logic        [DIFF_W-1:0]   mag;
  logic        [2*DIFF_W-1:0] prod;
  logic                       full;
  logic        [SUM_W:0]      sum_wide;
  logic        [DREM_W:0]     dshift;
  logic                       dge;
  logic        [SREM_W+1:0]   sshift;
  logic        [SREM_W+1:0]   strial;
  logic                       sge;

  logic [SQ_W-1:0]    sq_r;
  logic               add_r;
  logic [SUM_W-1:0]   sum_r;
  logic [COUNT_W-1:0] count_r;
  logic               ovf_r;
  logic [WORK_W-1:0]  work_r;
  logic [COUNT_W-1:0] divisor_r;
  logic [DREM_W-1:0]  drem_r;
  logic [SREM_W-1:0]  srem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [COUNT_W-1:0] res_count_r;
  logic               res_ovf_r;
  logic [RMS_W-1:0]   out_rms_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_ovf_r;

  assign diff     = DIFF_W'(ideal_sample) - DIFF_W'(approx_sample);
  assign mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign prod     = mag * mag;
  assign full     = (count_r == COUNT_MAX);
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(sq_r);

  assign dshift = {drem_r, work_r[WORK_W-1]};
  assign dge    = (dshift >= divisor_r);
  assign sshift = {srem_r, work_r[WORK_W-1 -: 2]};
  assign strial = (SREM_W+2)'({root_r, 2'b01});
  assign sge    = (sshift >= strial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_r   <= 1'b0;
      sum_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      add_r <= cmd.accept & ~full;
      if (cmd.load) begin
        sum_r   <= '0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (add_r) begin
          sum_r <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        end
        if (cmd.accept) begin
          if (full) begin
            ovf_r <= 1'b1;
          end else begin
            count_r <= count_r + COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq_r <= prod[SQ_W-1:0];
    end
    if (cmd.load) begin
      work_r      <= {sum_r, {FRAC_W{1'b0}}};
      divisor_r   <= count_r;
      res_count_r <= count_r;
      res_ovf_r   <= ovf_r;
      drem_r      <= '0;
      srem_r      <= '0;
      root_r      <= '0;
    end else if (cmd.div_step) begin
      if (dge) begin
        drem_r <= DREM_W'(dshift - divisor_r);
      end else begin
        drem_r <= dshift[DREM_W-1:0];
      end
      work_r <= {work_r[WORK_W-2:0], dge};
    end else if (cmd.sqrt_step) begin
      if (sge) begin
        srem_r <= SREM_W'(sshift - strial);
      end else begin
        srem_r <= sshift[SREM_W-1:0];
      end
      root_r <= {root_r[ROOT_W-2:0], sge};
      work_r <= {work_r[WORK_W-3:0], 2'b00};
    end
    if (cmd.out_load) begin
      out_rms_r   <= (root_r[ROOT_W-1:RMS_W] != '0) ? {RMS_W{1'b1}} : root_r[RMS_W-1:0];
      out_count_r <= res_count_r;
      out_ovf_r   <= res_ovf_r;
    end
  end

  assign rms_value  = out_rms_r;
  assign pair_count = out_count_r;
  assign overflow   = out_ovf_r;

endmodule

FILE: hw/rtl/rmsea_ctrl.sv
`include "rms_error_accumulator_top_defines.svh"

module rmsea_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rmsea_pkg::cmd_t cmd
);
  import rmsea_pkg::*;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [STEP_W-1:0]   step_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                div_last;
  logic                sqrt_last;

  assign in_ready  = (state_r == ST_ACCUM);
  assign div_last  = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sqrt_last = (step_r == STEP_W'(SQRT_STEPS - 1));

  always_comb begin
    cmd.accept    = in_ready & in_valid;
    cmd.load      = (state_r == ST_LOAD);
    cmd.div_step  = (state_r == ST_DIV);
    cmd.sqrt_step = (state_r == ST_SQRT);
    cmd.out_load  = (state_r == ST_DONE) & (~out_valid_r | out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_ACCUM: begin
        if (cmd.accept && in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (div_last) begin
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        step_nxt = step_r + STEP_W'(1);
        if (sqrt_last) begin
          step_nxt  = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (cmd.out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RMSEA_ASSERT_NEXT(a_last_stops_intake, clk, rst_n, cmd.accept && in_last, !in_ready)
  `RMSEA_ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `RMSEA_ASSERT_NEXT(a_div_to_sqrt, clk, rst_n, cmd.div_step && div_last, cmd.sqrt_step)
  `RMSEA_ASSERT_NEXT(a_out_load_valid, clk, rst_n, cmd.out_load, out_valid && in_ready)

endmodule

FILE: hw/rtl/rms_error_accumulator_top.sv
// Root-mean-square error of two sample streams. Pairs of signed 16-bit samples are
// accepted one per clock cycle while a data set streams in; the squared differences
// are summed in a 48-bit register and the pairs are counted, saturating at 65536 pairs
// with an overflow flag. The pair marked last is accumulated like the others, then
// the input stops while the square stage drains, the sum and count are loaded, the
// sum (times 2^16) is divided bit-serially by the count, the two-bits-per-cycle
// integer square root is taken and the result is moved into the output register.
// That last step waits, and the input stays stopped, while the result of the
// previous data set has not yet been transferred. The result is the RMS error times
// 256, truncated, with the pair count and the overflow flag; while it waits for its
// transfer, the next data set is accepted.
module rms_error_accumulator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rmsea_pkg::SAMPLE_W-1:0] in_ideal_sample,
  input  logic signed [rmsea_pkg::SAMPLE_W-1:0] in_approx_sample,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [rmsea_pkg::RMS_W-1:0]    out_rms_value,
  output logic        [rmsea_pkg::COUNT_W-1:0]  out_pair_count,
  output logic                                  out_overflow
);
  import rmsea_pkg::*;

  cmd_t cmd;

  rmsea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rmsea_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .ideal_sample  (in_ideal_sample),
    .approx_sample (in_approx_sample),
    .rms_value     (out_rms_value),
    .pair_count    (out_pair_count),
    .overflow      (out_overflow)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rmsea_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] ideal;
    logic signed [SAMPLE_W-1:0] approx;
    logic                       last;
    bit                         hold;
    bit                         burst;
  } sample_pair_t;

  typedef struct {
    logic [RMS_W-1:0]   rms;
    logic [COUNT_W-1:0] count;
    logic               ovf;
  } rms_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_ideal_sample = '0;
  logic signed [SAMPLE_W-1:0] in_approx_sample = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [RMS_W-1:0]           out_rms_value;
  logic [COUNT_W-1:0]         out_pair_count;
  logic                       out_overflow;

  sample_pair_t pending_pairs[$];
  rms_result_t  rms_expect_q[$];
  sample_pair_t cur_pair;
  int           gap_left = 0;
  int           stall_left = 0;
  int           errors = 0;

  logic [SUM_W-1:0]   sq_sum = '0;
  logic [COUNT_W-1:0] pair_cnt = '0;
  logic               drop_seen = 1'b0;

  rms_error_accumulator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ideal_sample  (in_ideal_sample),
    .in_approx_sample (in_approx_sample),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rms_value    (out_rms_value),
    .out_pair_count   (out_pair_count),
    .out_overflow     (out_overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] int_sqrt(input logic [63:0] x);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (32'd1 << i);
      if (64'(c) * 64'(c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic bit accumulate_pair(input sample_pair_t p, output rms_result_t r);
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] mag;
    logic [SQ_W:0]     sq;
    logic [SUM_W:0]    sum_next;
    logic [63:0]       scaled;
    logic [31:0]       root;
    r = '{default: '0};
    diff = {p.ideal[SAMPLE_W-1], p.ideal} - {p.approx[SAMPLE_W-1], p.approx};
    mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    sq = (SQ_W + 1)'(mag) * (SQ_W + 1)'(mag);
    if (pair_cnt >= COUNT_MAX) begin
      drop_seen = 1'b1;
    end else begin
      sum_next = {1'b0, sq_sum} + (SUM_W + 1)'(sq);
      sq_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
      pair_cnt = pair_cnt + 1'b1;
    end
    if (!p.last) return 1'b0;
    scaled = {sq_sum, 16'h0000} / 64'(pair_cnt);
    root = int_sqrt(scaled);
    r.rms = (root > 32'h00FF_FFFF) ? '1 : root[RMS_W-1:0];
    r.count = pair_cnt;
    r.ovf = drop_seen;
    sq_sum = '0;
    pair_cnt = '0;
    drop_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic add_pair(input int ideal, input int approx, input bit last,
                          input bit hold = 0, input bit burst = 0);
    sample_pair_t p;
    p.ideal = SAMPLE_W'(ideal);
    p.approx = SAMPLE_W'(approx);
    p.last = last;
    p.hold = hold;
    p.burst = burst;
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  always @(posedge clk) begin
    rms_result_t r;
    bit          done;
    bit          v;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(0, 6);
    end else begin
      done = in_valid && in_ready;
      if (done && accumulate_pair(cur_pair, r)) rms_expect_q.insert(rms_expect_q.size(), r);
      if (!in_valid || done) begin
        v = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pairs.size() > 0 &&
                     !(pending_pairs[0].hold && rms_expect_q.size() > 0)) begin
          cur_pair = pending_pairs.pop_front();
          in_ideal_sample <= cur_pair.ideal;
          in_approx_sample <= cur_pair.approx;
          in_last <= cur_pair.last;
          v = 1'b1;
          gap_left = cur_pair.burst ? 0 : $urandom_range(0, 6);
        end
        in_valid <= v;
      end
    end
  end

  always @(posedge clk) begin
    rms_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      if (out_valid && out_ready) begin
        if (rms_expect_q.size() == 0) begin
          $display("%0t: unexpected result transfer rms_value %0d pair_count %0d overflow %0d",
                   $time, out_rms_value, out_pair_count, out_overflow);
          errors++;
        end else begin
          e = rms_expect_q.pop_front();
          if (out_rms_value !== e.rms) begin
            $display("%0t: rms_value expected %0d actual %0d", $time, e.rms, out_rms_value);
            errors++;
          end
          if (out_pair_count !== e.count) begin
            $display("%0t: pair_count expected %0d actual %0d", $time, e.count,
                     out_pair_count);
            errors++;
          end
          if (out_overflow !== e.ovf) begin
            $display("%0t: overflow expected %0d actual %0d", $time, e.ovf, out_overflow);
            errors++;
          end
        end
        stall_left = $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int          n;
    int          len;
    int          style;
    int          ideal;
    int          approx;
    bit          burst;
    bit          hold;
    int          corner[5];
    corner = '{-32768, -1, 0, 1, 32767};

    add_pair(32767, -32768, 1);
    add_pair(-32768, 32767, 1);
    add_pair(0, 0, 1);
    add_pair(-32768, -32768, 1);
    add_pair(32767, 32767, 1);
    add_pair(1, 0, 1);
    add_pair(-1, 0, 0);
    add_pair(1, -1, 0);
    add_pair(12345, -12345, 1);
    add_pair(21845, -21846, 0);
    add_pair(-21846, 21845, 0);
    add_pair(0, 1, 0);
    add_pair(-32768, 0, 1);
    add_pair(100, 97, 0);
    add_pair(-5, 3, 0);
    add_pair(7, 7, 0);
    add_pair(32767, 0, 1);

    n = 0;
    for (int s = 0; n < 1200; s++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      style = $urandom_range(0, 3);
      burst = ($urandom_range(0, 7) == 0);
      hold = (s == 0) || ($urandom_range(0, 19) == 0);
      for (int k = 0; k < len; k++) begin
        ideal = $urandom_range(0, 65535);
        case (style)
          0: approx = $urandom_range(0, 65535);
          1: approx = ideal + $urandom_range(0, 32) - 16;
          2: begin
            ideal = corner[$urandom_range(0, 4)];
            approx = corner[$urandom_range(0, 4)];
          end
          default: approx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : ideal;
        endcase
        add_pair(ideal, approx, k == len - 1, hold && k == 0, burst);
        n++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_pairs.size() > 0 || in_valid || rms_expect_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0 && rms_expect_q.size() == 0) begin
      $display("[rms_error_accumulator_top] OK");
    end else begin
      $display("[rms_error_accumulator_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[rms_error_accumulator_top] ERROR");
    $finish;
  end

endmodule

FILE: rms_error_accumulator_top.f
+incdir+hw/rtl
hw/rtl/rmsea_pkg.sv
hw/rtl/rmsea_datapath.sv
hw/rtl/rmsea_ctrl.sv
hw/rtl/rms_error_accumulator_top.sv
test/tb_top.sv
